>>> rtl/sbec_pkg.sv
// Shared widths, payload structs and register indexes for the segment box entry clip.
package sbec_pkg;

   // Fixed number formats
   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int MARGIN_WIDTH = 31;
   localparam int TOL_WIDTH    = 16;
   // Signed crossing fraction, range [-2, 2] with FRAC_BITS fraction bits
   localparam int T_WIDTH      = FRAC_BITS + 3;
   // Lane pipeline: three front stages, one stage per quotient bit, one ordering stage
   localparam int LANE_LATENCY = FRAC_BITS + 5;
   localparam int CARRY_DEPTH  = FRAC_BITS + 4;
   localparam int PIPE_DEPTH   = LANE_LATENCY + 2;

   localparam logic signed [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << FRAC_BITS;
   localparam logic [T_WIDTH-1:0] T_SAT = T_WIDTH'(1) << (FRAC_BITS + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AREA_MARGIN    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ZERO_TOLERANCE = 1'b1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] outside_x;
      logic signed [COORD_WIDTH-1:0] outside_y;
      logic signed [COORD_WIDTH-1:0] outside_z;
      logic signed [COORD_WIDTH-1:0] inside_x;
      logic signed [COORD_WIDTH-1:0] inside_y;
      logic signed [COORD_WIDTH-1:0] inside_z;
      logic [COORD_WIDTH-2:0]        half_x;
      logic [COORD_WIDTH-2:0]        half_y;
      logic [COORD_WIDTH-2:0]        half_z;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic signed [COORD_WIDTH-1:0] border_x;
      logic signed [COORD_WIDTH-1:0] border_y;
      logic signed [COORD_WIDTH-1:0] border_z;
      logic [FRAC_BITS:0]            entry_fraction;
   } rsp_type;

   // Quotient magnitude leaving a divider, with its saturation and sign flags
   typedef struct packed {
      logic [FRAC_BITS:0] q;
      logic               sat;
      logic               neg;
   } div_type;

   // What one axis lane hands to the merge stage
   typedef struct packed {
      logic                          zero;
      logic                          bound_ok;
      logic signed [T_WIDTH-1:0]     t_lo;
      logic signed [T_WIDTH-1:0]     t_hi;
      logic signed [COORD_WIDTH-1:0] s;
      logic signed [COORD_WIDTH:0]   d;
   } lane_type;

endpackage

>>> rtl/sbec_div.sv
// Pipelined restoring divider: one quotient bit per stage, integer bit first.
module sbec_div import sbec_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic [COORD_WIDTH:0]   num,
   input  logic [COORD_WIDTH:0]   den,
   input  logic                   sat,
   input  logic                   neg,
   output div_type                quo
);

   localparam int STEPS = FRAC_BITS + 1;

   logic [COORD_WIDTH:0] rem_ff [STEPS];
   logic [COORD_WIDTH:0] den_ff [STEPS];
   logic [FRAC_BITS:0]   q_ff   [STEPS];
   logic                 sat_ff [STEPS];
   logic                 neg_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [COORD_WIDTH+1:0] trial;
      logic [COORD_WIDTH+1:0] diff;
      logic [COORD_WIDTH:0]   den_k;
      logic [FRAC_BITS:0]     q_prev;
      logic                   sat_k;
      logic                   neg_k;
      logic                   take;

      // first stage tests the integer bit on the raw numerator
      if (k == 0) begin : g_first
         assign trial  = {1'b0, num};
         assign den_k  = den;
         assign q_prev = '0;
         assign sat_k  = sat;
         assign neg_k  = neg;
      end else begin : g_next
         assign trial  = {rem_ff[k-1], 1'b0};
         assign den_k  = den_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign sat_k  = sat_ff[k-1];
         assign neg_k  = neg_ff[k-1];
      end

      assign diff = trial - {1'b0, den_k};
      assign take = trial >= {1'b0, den_k};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? diff[COORD_WIDTH:0] : trial[COORD_WIDTH:0];
            den_ff[k] <= den_k;
            q_ff[k]   <= {q_prev[FRAC_BITS-1:0], take};
            sat_ff[k] <= sat_k;
            neg_ff[k] <= neg_k;
         end
      end
   end

   assign quo.q   = q_ff[STEPS-1];
   assign quo.sat = sat_ff[STEPS-1];
   assign quo.neg = neg_ff[STEPS-1];

endmodule

>>> rtl/sbec_lane.sv
// One axis lane: widened extent, slab numerators, two dividers, fraction ordering.
module sbec_lane import sbec_pkg::*; (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] start_pt,
   input  logic signed [COORD_WIDTH-1:0] end_pt,
   input  logic [COORD_WIDTH-2:0]        half,
   input  logic [MARGIN_WIDTH-1:0]       margin,
   input  logic [TOL_WIDTH-1:0]          tol,
   output lane_type                      lane_out
);

   localparam int CW = COORD_WIDTH;

   // Stage 1: saturated extent and direction
   logic [CW-1:0]          hsum;
   logic signed [CW-1:0]   s1_ff;
   logic signed [CW:0]     d1_ff;
   logic [CW-2:0]          ext1_ff;

   assign hsum = CW'(half) + CW'(margin);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= start_pt;
         d1_ff   <= {end_pt[CW-1], end_pt} - {start_pt[CW-1], start_pt};
         ext1_ff <= hsum[CW-1] ? '1 : hsum[CW-2:0];
      end
   end

   // Stage 2: numerators, |d|, near-zero test and slab check
   logic signed [CW:0] ext_s;
   logic signed [CW:0] s_x;
   logic [CW:0]        ud_c;
   logic [CW:0]        n1_2_ff;
   logic [CW:0]        n2_2_ff;
   logic [CW:0]        ud2_ff;
   lane_type           carry_in;
   lane_type           carry_ff [CARRY_DEPTH];

   assign ext_s = $signed({2'b00, ext1_ff});
   assign s_x   = {s1_ff[CW-1], s1_ff};
   assign ud_c  = d1_ff[CW] ? (~d1_ff + 1'b1) : d1_ff;

   always_comb begin
      carry_in          = '0;
      carry_in.zero     = ud_c <= (CW+1)'(tol);
      carry_in.bound_ok = (s_x >= -ext_s) && (s_x <= ext_s);
      carry_in.s        = s1_ff;
      carry_in.d        = d1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_2_ff <= -ext_s - s_x;
         n2_2_ff <= ext_s - s_x;
         ud2_ff  <= ud_c;
      end
   end

   // Side data rides alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff[0] <= carry_in;
         for (int i = 1; i < CARRY_DEPTH; i++) begin
            carry_ff[i] <= carry_ff[i-1];
         end
      end
   end

   // Stage 3: magnitudes, quotient signs, saturation at two
   logic [CW:0] un1_c, un2_c;
   logic [CW:0] un1_3_ff, un2_3_ff, ud3_ff;
   logic        sat1_3_ff, sat2_3_ff, neg1_3_ff, neg2_3_ff;

   assign un1_c = n1_2_ff[CW] ? (~n1_2_ff + 1'b1) : n1_2_ff;
   assign un2_c = n2_2_ff[CW] ? (~n2_2_ff + 1'b1) : n2_2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         un1_3_ff  <= un1_c;
         un2_3_ff  <= un2_c;
         ud3_ff    <= ud2_ff;
         sat1_3_ff <= {1'b0, un1_c} >= {ud2_ff, 1'b0};
         sat2_3_ff <= {1'b0, un2_c} >= {ud2_ff, 1'b0};
         neg1_3_ff <= n1_2_ff[CW] ^ carry_ff[0].d[CW];
         neg2_3_ff <= n2_2_ff[CW] ^ carry_ff[0].d[CW];
      end
   end

   // Crossing fractions
   div_type dq1, dq2;

   sbec_div u_div_lo (
      .clock (clock),
      .en    (en),
      .num   (un1_3_ff),
      .den   (ud3_ff),
      .sat   (sat1_3_ff),
      .neg   (neg1_3_ff),
      .quo   (dq1)
   );

   sbec_div u_div_hi (
      .clock (clock),
      .en    (en),
      .num   (un2_3_ff),
      .den   (ud3_ff),
      .sat   (sat2_3_ff),
      .neg   (neg2_3_ff),
      .quo   (dq2)
   );

   // Ordering stage: apply saturation and sign, then sort the pair
   logic [T_WIDTH-1:0]        mag1, mag2;
   logic signed [T_WIDTH-1:0] t1, t2;
   logic signed [T_WIDTH-1:0] t_lo_ff, t_hi_ff;

   assign mag1 = dq1.sat ? T_SAT : T_WIDTH'(dq1.q);
   assign mag2 = dq2.sat ? T_SAT : T_WIDTH'(dq2.q);
   assign t1   = dq1.neg ? -$signed(mag1) : $signed(mag1);
   assign t2   = dq2.neg ? -$signed(mag2) : $signed(mag2);

   always_ff @(posedge clock) begin
      if (en) begin
         t_lo_ff <= (t1 > t2) ? t2 : t1;
         t_hi_ff <= (t1 > t2) ? t1 : t2;
      end
   end

   always_comb begin
      lane_out      = carry_ff[CARRY_DEPTH-1];
      lane_out.t_lo = t_lo_ff;
      lane_out.t_hi = t_hi_ff;
   end

endmodule

>>> rtl/sbec_merge.sv
// Merge of the three lanes: entry/exit interval, verdict and entry point.
module sbec_merge import sbec_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  lane_type lane_in [3],
   output rsp_type  rsp_out
);

   localparam int CW = COORD_WIDTH;

   // M1: fold the lane intervals, keep |d| and signs for the multiply
   logic signed [T_WIDTH-1:0] t_enter, t_exit;
   logic                      all_ok;
   logic                      found_c;
   logic [CW:0]               ud_c [3];

   always_comb begin
      t_enter = '0;
      t_exit  = T_ONE;
      all_ok  = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (lane_in[a].zero) begin
            all_ok = all_ok & lane_in[a].bound_ok;
         end else begin
            if (lane_in[a].t_lo > t_enter) t_enter = lane_in[a].t_lo;
            if (lane_in[a].t_hi < t_exit)  t_exit  = lane_in[a].t_hi;
         end
         ud_c[a] = lane_in[a].d[CW] ? (~lane_in[a].d + 1'b1) : lane_in[a].d;
      end
      found_c = all_ok && !(t_enter > t_exit);
   end

   logic                 found1_ff;
   logic [FRAC_BITS:0]   enter1_ff;
   logic [CW:0]          ud1_ff  [3];
   logic                 neg1_ff [3];
   logic signed [CW-1:0] s1_ff   [3];

   always_ff @(posedge clock) begin
      if (en) begin
         found1_ff <= found_c;
         enter1_ff <= found_c ? t_enter[FRAC_BITS:0] : '0;
         for (int a = 0; a < 3; a++) begin
            ud1_ff[a]  <= ud_c[a];
            neg1_ff[a] <= lane_in[a].d[CW];
            s1_ff[a]   <= lane_in[a].s;
         end
      end
   end

   // M2: offset magnitudes |d| * t_enter
   logic                    found2_ff;
   logic [FRAC_BITS:0]      enter2_ff;
   logic [CW+FRAC_BITS+1:0] prod2_ff [3];
   logic                    neg2_ff  [3];
   logic signed [CW-1:0]    s2_ff    [3];

   always_ff @(posedge clock) begin
      if (en) begin
         found2_ff <= found1_ff;
         enter2_ff <= enter1_ff;
         for (int a = 0; a < 3; a++) begin
            prod2_ff[a] <= (CW+FRAC_BITS+2)'(ud1_ff[a]) * (CW+FRAC_BITS+2)'(enter1_ff);
            neg2_ff[a]  <= neg1_ff[a];
            s2_ff[a]    <= s1_ff[a];
         end
      end
   end

   // Entry point: start plus signed, truncated offset
   logic [CW-1:0] off [3];
   logic [CW-1:0] pt  [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         off[a] = prod2_ff[a][CW+FRAC_BITS-1:FRAC_BITS];
         pt[a]  = found2_ff ? (s2_ff[a] + (neg2_ff[a] ? -off[a] : off[a])) : '0;
      end
      rsp_out.found          = found2_ff;
      rsp_out.border_x       = pt[0];
      rsp_out.border_y       = pt[1];
      rsp_out.border_z       = pt[2];
      rsp_out.entry_fraction = enter2_ff;
   end

endmodule

>>> rtl/segment_box_entry_clip.sv
// Top level: segment versus box entry clip, three axis lanes and a merge stage.
//
// Use: one segment/box beat enters on req_* (valid/ready) and one result beat
// leaves on rsp_* (valid/ready), in order. The segment runs from the outside
// point to the inside point; half-extents are widened by area_margin.
// Result: found, the entry point and the entry fraction (all zero if not found).
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 = area_margin, 1 = zero_tolerance); write only while the block is idle.
// Throughput: one beat per clock cycle while the output is not stalled.
// On its way to rsp_valid a beat passes the per-axis dividers, one quotient
// bit per stage, plus the front, ordering, merge, multiply and output
// register stages.
// Stall: when a result waits at the output register and rsp_ready is low, the
// whole pipeline holds and req_ready drops; nothing is lost or repeated.
// Reset: clears the pipeline valid bits, the output valid and both registers.
module segment_box_entry_clip import sbec_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_payload,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [MARGIN_WIDTH-1:0]    csr_wdata
);

   // Configuration registers
   logic [MARGIN_WIDTH-1:0] margin_ff;
   logic [TOL_WIDTH-1:0]    tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
         tol_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_AREA_MARGIN:    margin_ff <= csr_wdata;
            REG_ZERO_TOLERANCE: tol_ff    <= csr_wdata[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline advances whenever the output register is free or draining
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Axis lanes
   lane_type lane_res [3];

   sbec_lane u_lane_x (
      .clock    (clock),
      .en       (en),
      .start_pt (req_payload.outside_x),
      .end_pt   (req_payload.inside_x),
      .half     (req_payload.half_x),
      .margin   (margin_ff),
      .tol      (tol_ff),
      .lane_out (lane_res[0])
   );

   sbec_lane u_lane_y (
      .clock    (clock),
      .en       (en),
      .start_pt (req_payload.outside_y),
      .end_pt   (req_payload.inside_y),
      .half     (req_payload.half_y),
      .margin   (margin_ff),
      .tol      (tol_ff),
      .lane_out (lane_res[1])
   );

   sbec_lane u_lane_z (
      .clock    (clock),
      .en       (en),
      .start_pt (req_payload.outside_z),
      .end_pt   (req_payload.inside_z),
      .half     (req_payload.half_z),
      .margin   (margin_ff),
      .tol      (tol_ff),
      .lane_out (lane_res[2])
   );

   rsp_type merged;

   sbec_merge u_merge (
      .clock   (clock),
      .en      (en),
      .lane_in (lane_res),
      .rsp_out (merged)
   );

   // Beat tracking through the datapath, then the output register
   logic [PIPE_DEPTH-1:0] v_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= v_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= merged;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with an empty output register");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.entry_fraction == '0 &&
      rsp_payload.border_x == '0 && rsp_payload.border_y == '0 &&
      rsp_payload.border_z == '0)
      else $error("miss result carries a nonzero field");

   a_fraction_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |->
      rsp_payload.entry_fraction <= (FRAC_BITS+1)'(T_ONE))
      else $error("entry fraction above one");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && v_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
